FILE: sv/jss_pkg.sv
`default_nettype none

package jss_pkg;

  localparam int MaxRowsDef = 1024;
  localparam int MaxColsDef = 1024;

  localparam int CellW   = 32;
  localparam int SumW    = CellW + 2;
  localparam int ResW    = 64;
  localparam int PosW    = 10;
  localparam int CfgW    = 11;
  localparam int CfgIdxW = 1;

  localparam logic [CfgW-1:0] GridRowsReset = 11'd256;
  localparam logic [CfgW-1:0] GridColsReset = 11'd256;

  localparam int OutDataW = 120;

  typedef enum logic [CfgIdxW-1:0] {
    RegGridRows = 1'b0,
    RegGridCols = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KindPoint    = 1'b0,
    KindResidual = 1'b1
  } kind_e;

  // Control that travels with one transaction down the cell chain.
  typedef struct packed {
    logic            interior;
    logic            sweep_end;
    logic [PosW-1:0] row;
    logic [PosW-1:0] col;
  } tag_t;

endpackage

`default_nettype wire

FILE: sv/jss_line_store.sv
`default_nettype none

module jss_line_store import jss_pkg::*; #(
  parameter int MAX_COLS = MaxColsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         rd_en_i,
  input  wire logic [$clog2(MAX_COLS)-1:0]  col_i,
  input  wire logic [CellW-1:0]             bottom_i,
  output logic      [CellW-1:0]             up_o,
  output logic      [CellW-1:0]             mid_o,
  output logic      [CellW-1:0]             right_o
);

  localparam int CW = $clog2(MAX_COLS);

  logic [CellW-1:0] upper_mem [MAX_COLS];
  logic [CellW-1:0] middle_mem [MAX_COLS];

  logic [CellW-1:0] up_rd_q, mid_rd_q, right_rd_q;
  logic [CW-1:0]    wr_addr_q;
  logic             wr_pend_q;
  logic [CW-1:0]    right_col;

  assign right_col = (col_i == CW'(MAX_COLS - 1)) ? col_i : col_i + CW'(1);

  // The middle row entry moves into the upper row in the cycle after it is read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q             <= upper_mem[col_i];
      mid_rd_q            <= middle_mem[col_i];
      right_rd_q          <= middle_mem[right_col];
      middle_mem[col_i]   <= bottom_i;
      wr_addr_q           <= col_i;
    end
    if (wr_pend_q) begin
      upper_mem[wr_addr_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= rd_en_i;
    end
  end

  assign up_o    = up_rd_q;
  assign mid_o   = mid_rd_q;
  assign right_o = right_rd_q;

endmodule

`default_nettype wire

FILE: sv/jss_relax_cell.sv
`default_nettype none

module jss_relax_cell import jss_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             vld_i,
  input  wire tag_t             tag_i,
  input  wire logic [CellW-1:0] up_i,
  input  wire logic [CellW-1:0] center_i,
  input  wire logic [CellW-1:0] bottom_i,
  input  wire logic [CellW-1:0] left_i,
  input  wire logic [CellW-1:0] right_i,
  output logic                  vld_o,
  output tag_t                  tag_o,
  output logic      [CellW-1:0] nv_o,
  output logic      [CellW-1:0] absd_o
);

  logic [SumW-1:0]  sum;
  logic [CellW-1:0] nv;
  logic [CellW:0]   diff;
  logic [CellW-1:0] absd;
  logic             vld_q;
  tag_t             tag_q;
  logic [CellW-1:0] nv_q, absd_q;

  always_comb begin
    sum  = {{2{up_i[CellW-1]}}, up_i} + {{2{bottom_i[CellW-1]}}, bottom_i}
         + {{2{left_i[CellW-1]}}, left_i} + {{2{right_i[CellW-1]}}, right_i};
    // Floor of the quarter; the result always fits the cell width.
    nv   = sum[SumW-1:2];
    diff = {nv[CellW-1], nv} - {center_i[CellW-1], center_i};
    absd = diff[CellW] ? CellW'((CellW+1)'(0) - diff) : diff[CellW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q  <= tag_i;
      nv_q   <= nv;
      absd_q <= absd;
    end
  end

  assign vld_o  = vld_q;
  assign tag_o  = tag_q;
  assign nv_o   = nv_q;
  assign absd_o = absd_q;

endmodule

`default_nettype wire

FILE: sv/jss_square_cell.sv
`default_nettype none

module jss_square_cell import jss_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             vld_i,
  input  wire tag_t             tag_i,
  input  wire logic [CellW-1:0] nv_i,
  input  wire logic [CellW-1:0] absd_i,
  output logic                  vld_o,
  output tag_t                  tag_o,
  output logic      [CellW-1:0] nv_o,
  output logic      [ResW-1:0]  sq_o
);

  logic             vld_q;
  tag_t             tag_q;
  logic [CellW-1:0] nv_q;
  logic [ResW-1:0]  sq_q;
  logic [ResW-1:0]  prod;

  assign prod = ResW'(absd_i) * ResW'(absd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q <= tag_i;
      nv_q  <= nv_i;
      sq_q  <= prod;
    end
  end

  assign vld_o = vld_q;
  assign tag_o = tag_q;
  assign nv_o  = nv_q;
  assign sq_o  = sq_q;

endmodule

`default_nettype wire

FILE: sv/jss_accum_cell.sv
`default_nettype none

module jss_accum_cell import jss_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             adv_i,
  input  wire logic             vld_i,
  input  wire tag_t             tag_i,
  input  wire logic [CellW-1:0] nv_i,
  input  wire logic [ResW-1:0]  sq_i,
  output logic                  vld_o,
  output kind_e                 kind_o,
  output logic      [PosW-1:0]  row_o,
  output logic      [PosW-1:0]  col_o,
  output logic      [CellW-1:0] nv_o,
  output logic      [ResW-1:0]  res_o,
  output logic                  last_o
);

  logic [ResW:0]    acc_sum;
  logic [ResW-1:0]  acc_sat;
  logic [ResW-1:0]  total_q;
  logic             vld_q;
  kind_e            kind_q;
  logic [PosW-1:0]  row_q, col_q;
  logic [CellW-1:0] nv_q;
  logic [ResW-1:0]  res_q;
  logic             last_q;

  always_comb begin
    acc_sum = {1'b0, total_q} + {1'b0, sq_i};
    acc_sat = acc_sum[ResW] ? {ResW{1'b1}} : acc_sum[ResW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      total_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_i;
      if (vld_i) begin
        if (tag_i.sweep_end) begin
          total_q <= '0;
        end else begin
          total_q <= acc_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (tag_i.sweep_end) begin
        kind_q <= KindResidual;
        row_q  <= '0;
        col_q  <= '0;
        nv_q   <= '0;
        res_q  <= total_q;
        last_q <= 1'b1;
      end else begin
        kind_q <= KindPoint;
        row_q  <= tag_i.row;
        col_q  <= tag_i.col;
        nv_q   <= nv_i;
        res_q  <= '0;
        last_q <= 1'b0;
      end
    end
  end

  assign vld_o  = vld_q;
  assign kind_o = kind_q;
  assign row_o  = row_q;
  assign col_o  = col_q;
  assign nv_o   = nv_q;
  assign res_o  = res_q;
  assign last_o = last_q;

endmodule

`default_nettype wire

FILE: sv/jacobi_stencil_sweep.sv
// One Jacobi sweep of the five-point heat stencil over a grid streamed in raster order.
// The slave stream carries one signed Q16.16 grid value per transaction. The master
// stream carries one transaction per interior point, with its row, column and relaxed
// value, and a final transaction per sweep (tuser high, tlast high) that carries the
// saturating Q32.32 sum of squared changes; that sum is cleared for the next sweep.
// Grid size comes from the write port: index 0 is the row count, index 1 the column
// count, both including boundaries and clamped into 3 to the maximum. Write them only
// while no transaction is in flight.
// A grid value is registered in turn by a four-stage chain: line read, relax, square,
// accumulate and output. Throughput: one grid value per cycle while the master side does
// not stall, set by the line stores, which read and write the middle row on accept and
// write the upper row from a register, and by the chain.
// A stall on the master side freezes the whole chain and drops s_axis_tready in the
// same cycle; nothing is lost. Reset clears the position, the residual and all valid
// bits; line store contents are undefined until the first rows of a sweep write them.
`default_nettype none

module jacobi_stencil_sweep import jss_pkg::*; #(
  parameter int MAX_ROWS = MaxRowsDef,
  parameter int MAX_COLS = MaxColsDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [CellW-1:0]    s_axis_tdata,   // [31:0] cell_value
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [OutDataW-1:0] m_axis_tdata,   // row, col, new_value, residual_sum
  output logic                     m_axis_tuser,   // kind
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_data_i
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  logic [CfgW-1:0] grid_rows_q, grid_cols_q;
  logic [RW-1:0]   rows_m1, row_q;
  logic [CW-1:0]   cols_m1, col_q;
  logic            adv, accept, row_end, sweep_end, interior;
  tag_t            tag;

  logic             s1_vld_q;
  tag_t             s1_tag_q;
  logic [CellW-1:0] bottom_q, left_q;
  logic [CellW-1:0] up_rd, mid_rd, right_rd;

  logic             s2_vld, s3_vld, out_vld;
  tag_t             s2_tag, s3_tag;
  logic [CellW-1:0] s2_nv, s2_absd, s3_nv, out_nv;
  logic [ResW-1:0]  s3_sq, out_res;
  kind_e            out_kind;
  logic [PosW-1:0]  out_row, out_col;
  logic             out_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GridRowsReset;
      grid_cols_q <= GridColsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegGridRows: grid_rows_q <= cfg_data_i;
        RegGridCols: grid_cols_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (int'(grid_rows_q) < 3) begin
      rows_m1 = RW'(2);
    end else if (int'(grid_rows_q) > MAX_ROWS) begin
      rows_m1 = RW'(MAX_ROWS - 1);
    end else begin
      rows_m1 = RW'(int'(grid_rows_q) - 1);
    end
    if (int'(grid_cols_q) < 3) begin
      cols_m1 = CW'(2);
    end else if (int'(grid_cols_q) > MAX_COLS) begin
      cols_m1 = CW'(MAX_COLS - 1);
    end else begin
      cols_m1 = CW'(int'(grid_cols_q) - 1);
    end
  end

  assign adv           = !out_vld || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  always_comb begin
    row_end   = col_q >= cols_m1;
    sweep_end = row_end && (row_q >= rows_m1);
    interior  = (row_q >= RW'(2)) && (row_q <= rows_m1)
             && (col_q >= CW'(1)) && (col_q <= cols_m1 - CW'(1));
    tag.interior  = interior;
    tag.sweep_end = sweep_end;
    tag.row       = PosW'(row_q - RW'(1));
    tag.col       = PosW'(col_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      left_q   <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (adv) begin
        s1_vld_q <= accept && (interior || sweep_end);
      end
      if (accept) begin
        left_q <= mid_rd;
        if (sweep_end) begin
          row_q <= '0;
          col_q <= '0;
        end else if (row_end) begin
          row_q <= row_q + RW'(1);
          col_q <= '0;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_tag_q <= tag;
      bottom_q <= s_axis_tdata;
    end
  end

  jss_line_store #(
    .MAX_COLS (MAX_COLS)
  ) u_line_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .col_i    (col_q),
    .bottom_i (s_axis_tdata),
    .up_o     (up_rd),
    .mid_o    (mid_rd),
    .right_o  (right_rd)
  );

  jss_relax_cell u_relax (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .vld_i    (s1_vld_q),
    .tag_i    (s1_tag_q),
    .up_i     (up_rd),
    .center_i (mid_rd),
    .bottom_i (bottom_q),
    .left_i   (left_q),
    .right_i  (right_rd),
    .vld_o    (s2_vld),
    .tag_o    (s2_tag),
    .nv_o     (s2_nv),
    .absd_o   (s2_absd)
  );

  jss_square_cell u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s2_vld),
    .tag_i  (s2_tag),
    .nv_i   (s2_nv),
    .absd_i (s2_absd),
    .vld_o  (s3_vld),
    .tag_o  (s3_tag),
    .nv_o   (s3_nv),
    .sq_o   (s3_sq)
  );

  jss_accum_cell u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s3_vld),
    .tag_i  (s3_tag),
    .nv_i   (s3_nv),
    .sq_i   (s3_sq),
    .vld_o  (out_vld),
    .kind_o (out_kind),
    .row_o  (out_row),
    .col_o  (out_col),
    .nv_o   (out_nv),
    .res_o  (out_res),
    .last_o (out_last)
  );

  assign m_axis_tvalid = out_vld;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'b0000, out_res, out_nv, out_col, out_row};

  // The deferred upper-row write never targets the column being read.
  a_no_wr_rd_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (u_line_store.wr_pend_q && accept) |-> (u_line_store.wr_addr_q != col_q))
    else $error("upper line write collides with read");

  // The end of a sweep returns the position to the first point of the grid.
  a_sweep_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && sweep_end) |=> (row_q == '0 && col_q == '0))
    else $error("position not cleared after sweep end");

  // A point result carries no residual, and only the residual result is last.
  a_point_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == KindPoint))
      |-> (m_axis_tdata[115:52] == '0 && !m_axis_tlast))
    else $error("point result carries residual fields");

endmodule

`default_nettype wire
